// ===== hw/rtl/flba_pkg.sv =====
// Shared types and constants for the free-list block allocator.
// No dependencies.
package flba_pkg;

   localparam int FREE_ENTRIES_DEF = 16;
   localparam int USED_ENTRIES_DEF = 16;
   localparam int ADDR_BITS_DEF    = 32;
   localparam int SIZE_BITS        = 32;
   localparam int STATUS_BITS      = 3;
   localparam logic [31:0] HEAP_SIZE_RESET = 32'd65536;

   localparam logic [STATUS_BITS-1:0] ST_REUSED    = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_EXTENDED  = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NO_MEMORY = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_USED_FULL = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_FREE_FULL = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_RELEASED  = 3'd6;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic CSR_FIT_MODE  = 1'b0;
   localparam logic CSR_HEAP_SIZE = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] request_size;
      logic [31:0] block_address;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [31:0] granted_size;
      logic [2:0]  status;
   } rsp_type;

endpackage

// ===== hw/rtl/flba_if.sv =====
// Valid/ready channel interfaces for request, response and register write.
// Depends on flba_pkg.
interface flba_req_if;
   logic              valid;
   logic              ready;
   flba_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface flba_rsp_if;
   logic              valid;
   logic              ready;
   flba_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface flba_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] index;
   logic [31:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/flba_front.sv =====
// Front end: takes requests and queues them for the back end (two-entry queue).
// Depends on flba_pkg.
module flba_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  flba_pkg::req_type in_data,
   output logic              q_valid,
   input  logic              q_ready,
   output flba_pkg::req_type q_data
);
   flba_pkg::req_type slot_ff [2];
   flba_pkg::req_type slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = slot_ff[rd_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   // advance read pointer and count, and store a pushed entry
   always_comb begin
      slot_in = slot_ff;
      rd_in   = pop ? ~rd_ff : rd_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
      if (push) begin
         slot_in[rd_ff ^ cnt_ff[0]] = in_data;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("queue overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count step");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("pop empty");
`endif
endmodule

// ===== hw/rtl/flba_back.sv =====
// Back end: scans the free and used tables one entry a cycle, updates state.
// Depends on flba_pkg.
module flba_back #(
   parameter int FREE_ENTRIES = flba_pkg::FREE_ENTRIES_DEF,
   parameter int USED_ENTRIES = flba_pkg::USED_ENTRIES_DEF,
   parameter int ADDR_BITS    = flba_pkg::ADDR_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  flba_pkg::req_type q_data,
   input  logic              fit_mode,
   input  logic [31:0]       heap_size,
   output logic              out_valid,
   input  logic              out_ready,
   output flba_pkg::rsp_type out_data
);
   localparam int FB = $clog2(FREE_ENTRIES);
   localparam int UB = $clog2(USED_ENTRIES);
   localparam int FC = $clog2(FREE_ENTRIES + 1);
   localparam int UC = $clog2(USED_ENTRIES + 1);
   // bump pointer width: wide enough for heap_size plus one request
   localparam int TW = ((ADDR_BITS > flba_pkg::SIZE_BITS) ? ADDR_BITS : flba_pkg::SIZE_BITS) + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_USCAN, S_FSCAN, S_DECIDE, S_SHIFT, S_DONE
   } state_type;

   state_type state_ff;
   flba_pkg::req_type cur_ff;
   logic [FREE_ENTRIES-1:0][31:0] fsize_ff;
   logic [FREE_ENTRIES-1:0][31:0] faddr_ff;
   logic [USED_ENTRIES-1:0][31:0] usize_ff;
   logic [USED_ENTRIES-1:0][31:0] uaddr_ff;
   logic [USED_ENTRIES-1:0]       uvalid_ff;
   logic [FC-1:0] fcount_ff;
   logic [TW-1:0] top_ff;
   logic [UC-1:0] ui_ff;
   logic [FC-1:0] fi_ff;
   logic          uhit_ff;
   logic [UB-1:0] uslot_ff;
   logic          fhit_ff;
   logic [FB-1:0] fpick_ff;
   logic [31:0]   best_ff;
   flba_pkg::rsp_type res_ff;
   flba_pkg::rsp_type rsp_ff;
   logic          ovalid_ff;

   logic [UB-1:0] ui_idx;
   logic [FB-1:0] fi_idx;
   logic [31:0]   fsz;
   logic [31:0]   surplus;
   logic [TW-1:0] new_top;
   logic [TW-1:0] heap_lim;
   logic [TW-1:0] addr_lim;
   logic [31:0]   top_lo;

   assign ui_idx   = ui_ff[UB-1:0];
   assign fi_idx   = fi_ff[FB-1:0];
   assign fsz      = fsize_ff[fi_idx];
   assign surplus  = fsz - cur_ff.request_size;
   assign q_ready  = (state_ff == S_IDLE);
   assign out_valid = ovalid_ff;
   assign out_data  = rsp_ff;

   // bump-pointer limit and candidate new top
   assign new_top  = top_ff + TW'(cur_ff.request_size);
   assign heap_lim = TW'(heap_size);
   assign addr_lim = (TW'(1) << ADDR_BITS) - TW'(1);
   assign top_lo   = top_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         uvalid_ff <= '0;
         fcount_ff <= '0;
         top_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff   <= q_data;
                  ui_ff    <= '0;
                  fi_ff    <= '0;
                  uhit_ff  <= 1'b0;
                  fhit_ff  <= 1'b0;
                  state_ff <= S_USCAN;
               end
            end
            // find lowest free used slot, or lowest valid address match
            S_USCAN: begin
               if (ui_ff == UC'(USED_ENTRIES) || uhit_ff) begin
                  state_ff <= (cur_ff.kind == flba_pkg::KIND_ALLOC && uhit_ff)
                              ? S_FSCAN : S_DECIDE;
               end else begin
                  if (cur_ff.kind == flba_pkg::KIND_ALLOC) begin
                     if (!uvalid_ff[ui_idx]) begin
                        uhit_ff  <= 1'b1;
                        uslot_ff <= ui_idx;
                     end
                  end else if (uvalid_ff[ui_idx] &&
                               uaddr_ff[ui_idx] == cur_ff.block_address) begin
                     uhit_ff  <= 1'b1;
                     uslot_ff <= ui_idx;
                  end
                  ui_ff <= ui_ff + 1'b1;
               end
            end
            // walk the free table in release order
            S_FSCAN: begin
               if (fi_ff == fcount_ff || (fhit_ff && !fit_mode)) begin
                  state_ff <= S_DECIDE;
               end else begin
                  if (fsz >= cur_ff.request_size &&
                      (!fhit_ff || surplus < best_ff)) begin
                     fhit_ff  <= 1'b1;
                     fpick_ff <= fi_idx;
                     best_ff  <= surplus;
                  end
                  fi_ff <= fi_ff + 1'b1;
               end
            end
            // build the result and update the tables
            S_DECIDE: begin
               state_ff <= S_DONE;
               if (cur_ff.kind == flba_pkg::KIND_ALLOC) begin
                  if (!uhit_ff) begin
                     res_ff <= '{32'd0, 32'd0, flba_pkg::ST_USED_FULL};
                  end else if (fhit_ff) begin
                     res_ff <= '{faddr_ff[fpick_ff], fsize_ff[fpick_ff],
                                 flba_pkg::ST_REUSED};
                     usize_ff[uslot_ff]  <= fsize_ff[fpick_ff];
                     uaddr_ff[uslot_ff]  <= faddr_ff[fpick_ff];
                     uvalid_ff[uslot_ff] <= 1'b1;
                     fi_ff    <= FC'(fpick_ff);
                     state_ff <= S_SHIFT;
                  end else if (new_top > heap_lim || new_top > addr_lim) begin
                     res_ff <= '{32'd0, 32'd0, flba_pkg::ST_NO_MEMORY};
                  end else begin
                     res_ff <= '{top_lo, cur_ff.request_size, flba_pkg::ST_EXTENDED};
                     usize_ff[uslot_ff]  <= cur_ff.request_size;
                     uaddr_ff[uslot_ff]  <= top_lo;
                     uvalid_ff[uslot_ff] <= 1'b1;
                     top_ff <= new_top;
                  end
               end else begin
                  if (!uhit_ff) begin
                     res_ff <= '{32'd0, 32'd0, flba_pkg::ST_NOT_FOUND};
                  end else if (fcount_ff == FC'(FREE_ENTRIES)) begin
                     res_ff <= '{32'd0, 32'd0, flba_pkg::ST_FREE_FULL};
                  end else begin
                     res_ff <= '{32'd0, usize_ff[uslot_ff], flba_pkg::ST_RELEASED};
                     fsize_ff[fcount_ff[FB-1:0]] <= usize_ff[uslot_ff];
                     faddr_ff[fcount_ff[FB-1:0]] <= uaddr_ff[uslot_ff];
                     fcount_ff <= fcount_ff + 1'b1;
                     uvalid_ff[uslot_ff] <= 1'b0;
                  end
               end
            end
            // compact the free table one entry a cycle
            S_SHIFT: begin
               if (fi_ff + 1'b1 >= fcount_ff) begin
                  fcount_ff <= fcount_ff - 1'b1;
                  state_ff  <= S_DONE;
               end else begin
                  fsize_ff[fi_idx] <= fsize_ff[fi_idx + 1'b1];
                  faddr_ff[fi_idx] <= faddr_ff[fi_idx + 1'b1];
                  fi_ff <= fi_ff + 1'b1;
               end
            end
            // hand the result over once the output register is free
            S_DONE: begin
               if (!ovalid_ff || out_ready) begin
                  rsp_ff    <= res_ff;
                  ovalid_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (ovalid_ff && out_ready && !(state_ff == S_DONE)) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_fcount_range: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= FC'(FREE_ENTRIES)) else $error("free count range");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> state_ff == S_USCAN) else $error("take");
   a_reuse_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT && $past(state_ff) == S_DECIDE |-> fcount_ff != '0)
      else $error("reuse from empty table");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("result lost");
`endif
endmodule

// ===== hw/rtl/free_list_block_allocator.sv =====
// Top level of the free-list block allocator: registers, front queue, back end.
// Depends on flba_pkg, flba_if, flba_front, flba_back.
// From request transfer to response valid a request passes the front queue, the used
// scan, the free scan and, after reuse, the compaction of the free table.
// The back end holds one request at a time, and a waiting response stalls it.
// Reset: synchronous; tables empty, heap top zero, fit_mode 0, heap_size 65536.
module free_list_block_allocator #(
   parameter int FREE_ENTRIES = flba_pkg::FREE_ENTRIES_DEF,
   parameter int USED_ENTRIES = flba_pkg::USED_ENTRIES_DEF,
   parameter int ADDR_BITS    = flba_pkg::ADDR_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   flba_req_if.sink   req,
   flba_rsp_if.source rsp,
   flba_csr_if.sink   csr
);
   logic              fit_mode_ff;
   logic [31:0]       heap_size_ff;
   logic              q_valid, q_ready;
   flba_pkg::req_type q_data;

   assign csr.ready = 1'b1;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= 1'b0;
         heap_size_ff <= flba_pkg::HEAP_SIZE_RESET;
      end else if (csr.valid) begin
         if (csr.index == 32'(flba_pkg::CSR_FIT_MODE)) begin
            fit_mode_ff <= csr.wdata[0];
         end else if (csr.index == 32'(flba_pkg::CSR_HEAP_SIZE)) begin
            heap_size_ff <= csr.wdata;
         end
      end
   end

   flba_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .q_valid, .q_ready, .q_data
   );

   flba_back #(
      .FREE_ENTRIES(FREE_ENTRIES), .USED_ENTRIES(USED_ENTRIES), .ADDR_BITS(ADDR_BITS)
   ) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_data,
      .fit_mode(fit_mode_ff), .heap_size(heap_size_ff),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule
